// ===== sv/afu_pkg.sv =====
`default_nettype none

package afu_pkg;

    // Fixed-point format: always 12 fraction bits, so 1.0 is 4096.
    localparam int FRAC_BITS     = 12;
    localparam int FRAC_ONE      = 1 << FRAC_BITS;

    // The sigmoid table spans [-8, 8) as a 16-bit argument in 64 segments.
    localparam int SIG_ARG_BITS  = 16;
    localparam int SIG_SEGS      = 64;
    localparam int SEG_BITS      = 6;
    localparam int SEG_FRAC_BITS = SIG_ARG_BITS - SEG_BITS;
    localparam int SIG_OUT_BITS  = 12;

    // Configuration port widths and register indexes.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_KIND = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIR  = 8'd1;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_SIGMOID = 2'd1,
        ACT_RELU    = 2'd2,
        ACT_TANH    = 2'd3
    } t_act_kind;

    typedef enum logic {
        DIR_FWD = 1'b0,
        DIR_BWD = 1'b1
    } t_dir;

    typedef struct packed {
        t_act_kind kind;
        t_dir      dir;
    } t_afu_cfg;

    // Segment endpoints of the logistic sigmoid, rounded to Q0.12.
    localparam logic [SIG_OUT_BITS-1:0] SIG_TAB [0:SIG_SEGS] = '{
        12'd1,    12'd2,    12'd2,    12'd3,    12'd4,    12'd5,    12'd6,    12'd8,
        12'd10,   12'd13,   12'd17,   12'd21,   12'd27,   12'd35,   12'd45,   12'd58,
        12'd74,   12'd94,   12'd120,  12'd153,  12'd194,  12'd246,  12'd311,  12'd391,
        12'd488,  12'd606,  12'd747,  12'd912,  12'd1102, 12'd1314, 12'd1546, 12'd1793,
        12'd2048,
        12'd2303, 12'd2550, 12'd2782, 12'd2994, 12'd3184, 12'd3349, 12'd3490, 12'd3608,
        12'd3705, 12'd3785, 12'd3850, 12'd3902, 12'd3943, 12'd3976, 12'd4002, 12'd4022,
        12'd4038, 12'd4051, 12'd4061, 12'd4069, 12'd4075, 12'd4079, 12'd4083, 12'd4086,
        12'd4088, 12'd4090, 12'd4091, 12'd4092, 12'd4093, 12'd4094, 12'd4094, 12'd4095
    };

endpackage

`default_nettype wire

// ===== sv/afu_core.sv =====
`default_nettype none

module afu_core #(
    parameter int DATA_WIDTH = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  afu_pkg::t_afu_cfg            i_cfg,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire signed [DATA_WIDTH-1:0]  i_value,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic signed [DATA_WIDTH-1:0] o_result
);
    import afu_pkg::*;

    localparam int W      = DATA_WIDTH;
    localparam int EXT_W  = (W > SIG_ARG_BITS) ? W : SIG_ARG_BITS;
    localparam int BASE_W = (W > FRAC_BITS + 1) ? W : FRAC_BITS + 1;
    localparam int B_W    = BASE_W + 1;
    localparam int P_W    = W + B_W;
    localparam int Q_W    = P_W - FRAC_BITS;
    localparam int SP_W   = SIG_OUT_BITS + SEG_FRAC_BITS;
    localparam int T_W    = SIG_OUT_BITS + 2;
    localparam int TM_W   = SIG_OUT_BITS + 1;
    localparam int TP_W   = 2 * TM_W;
    localparam int STAGES = 5;

    localparam logic signed [W-1:0]     V_MAX  = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]     V_MIN  = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [EXT_W-1:0] ARG_HI = EXT_W'((1 << (SIG_ARG_BITS - 1)) - 1);
    localparam logic signed [EXT_W-1:0] ARG_LO = EXT_W'(-(1 << (SIG_ARG_BITS - 1)));
    localparam logic signed [P_W-1:0]   R_MAX  = P_W'(V_MAX);
    localparam logic signed [P_W-1:0]   R_MIN  = P_W'(V_MIN);

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] stg_rdy;

    // Stage 0: argument shaping and table lookup.
    t_afu_cfg                  r_s0_cfg;
    logic signed [W-1:0]       r_s0_v;
    logic [SIG_OUT_BITS-1:0]   r_s0_lo;
    logic [SIG_OUT_BITS-1:0]   r_s0_diff;
    logic [SEG_FRAC_BITS-1:0]  r_s0_frac;
    logic signed [B_W-1:0]     r_s0_b;
    // Stage 1: multiplications.
    t_afu_cfg                  r_s1_cfg;
    logic signed [W-1:0]       r_s1_v;
    logic [SIG_OUT_BITS-1:0]   r_s1_lo;
    logic [SP_W-1:0]           r_s1_sp;
    logic signed [P_W-1:0]     r_s1_bp;
    // Stage 2: interpolation and tanh rescale.
    t_afu_cfg                  r_s2_cfg;
    logic signed [W-1:0]       r_s2_v;
    logic [SIG_OUT_BITS-1:0]   r_s2_s;
    logic signed [T_W-1:0]     r_s2_t;
    logic signed [Q_W-1:0]     r_s2_q;
    // Stage 3: tanh derivative product.
    t_afu_cfg                  r_s3_cfg;
    logic signed [W-1:0]       r_s3_v;
    logic [SIG_OUT_BITS-1:0]   r_s3_s;
    logic signed [T_W-1:0]     r_s3_t;
    logic signed [Q_W-1:0]     r_s3_q;
    logic [TP_W-1:0]           r_s3_tp;
    // Stage 4: output register.
    logic signed [W-1:0]       r_s4_res;

    logic signed [W-1:0]       n_s0_arg;
    logic signed [EXT_W-1:0]   n_s0_ext;
    logic [SIG_ARG_BITS-1:0]   n_s0_u;
    logic [SEG_BITS-1:0]       n_s0_idx;
    logic [SIG_OUT_BITS-1:0]   n_s0_lo;
    logic [SIG_OUT_BITS-1:0]   n_s0_hi;
    logic signed [B_W-1:0]     n_s0_b;
    logic [SP_W-1:0]           n_s1_sp;
    logic signed [P_W-1:0]     n_s1_bp;
    logic [SIG_OUT_BITS-1:0]   n_s2_s;
    logic signed [T_W-1:0]     n_s2_t;
    logic signed [T_W-1:0]     n_s3_am;
    logic signed [T_W-1:0]     n_s3_ap;
    logic [TP_W-1:0]           n_s3_tp;
    logic signed [P_W-1:0]     n_s4_wide;
    logic signed [W-1:0]       n_s4_res;

    // A stage can load when it is empty or its content moves on.
    always_comb begin
        stg_rdy[STAGES-1] = !r_vld[STAGES-1] || i_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            stg_rdy[k] = !r_vld[k] || stg_rdy[k+1];
        end
    end

    assign o_ready  = stg_rdy[0];
    assign o_valid  = r_vld[STAGES-1];
    assign o_result = r_s4_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_rdy[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < STAGES; k++) begin
                if (stg_rdy[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Stage 0: tanh doubles its argument with saturation, then the argument is
    // clamped to the table span and split into segment index and fraction.
    always_comb begin
        if (i_cfg.kind == ACT_TANH) begin
            if (i_value[W-1] != i_value[W-2]) begin
                n_s0_arg = i_value[W-1] ? V_MIN : V_MAX;
            end else begin
                n_s0_arg = {i_value[W-2:0], 1'b0};
            end
        end else begin
            n_s0_arg = i_value;
        end
        n_s0_ext = EXT_W'(n_s0_arg);
        if (n_s0_ext > ARG_HI) begin
            n_s0_ext = ARG_HI;
        end else if (n_s0_ext < ARG_LO) begin
            n_s0_ext = ARG_LO;
        end
        n_s0_u   = {~n_s0_ext[SIG_ARG_BITS-1], n_s0_ext[SIG_ARG_BITS-2:0]};
        n_s0_idx = n_s0_u[SIG_ARG_BITS-1 -: SEG_BITS];
        n_s0_lo  = SIG_TAB[n_s0_idx];
        n_s0_hi  = SIG_TAB[{1'b0, n_s0_idx} + (SEG_BITS+1)'(1)];
        n_s0_b   = B_W'(FRAC_ONE) - B_W'(i_value);
    end

    always_ff @(posedge i_clk) begin
        if (stg_rdy[0]) begin
            r_s0_cfg  <= i_cfg;
            r_s0_v    <= i_value;
            r_s0_lo   <= n_s0_lo;
            r_s0_diff <= n_s0_hi - n_s0_lo;
            r_s0_frac <= n_s0_u[SEG_FRAC_BITS-1:0];
            r_s0_b    <= n_s0_b;
        end
    end

    // Stage 1: interpolation product and the sigmoid derivative product.
    assign n_s1_sp = SP_W'(r_s0_diff) * SP_W'(r_s0_frac);
    assign n_s1_bp = r_s0_v * r_s0_b;

    always_ff @(posedge i_clk) begin
        if (stg_rdy[1]) begin
            r_s1_cfg <= r_s0_cfg;
            r_s1_v   <= r_s0_v;
            r_s1_lo  <= r_s0_lo;
            r_s1_sp  <= n_s1_sp;
            r_s1_bp  <= n_s1_bp;
        end
    end

    // Stage 2: finish the sigmoid and form tanh = 2*sigmoid - 1.
    assign n_s2_s = r_s1_lo + r_s1_sp[SP_W-1:SEG_FRAC_BITS];
    assign n_s2_t = $signed({1'b0, n_s2_s, 1'b0}) - T_W'(FRAC_ONE);

    always_ff @(posedge i_clk) begin
        if (stg_rdy[2]) begin
            r_s2_cfg <= r_s1_cfg;
            r_s2_v   <= r_s1_v;
            r_s2_s   <= n_s2_s;
            r_s2_t   <= n_s2_t;
            r_s2_q   <= r_s1_bp[P_W-1:FRAC_BITS];
        end
    end

    // Stage 3: (1 - t) * (1 + t); both factors lie in (0, 2).
    assign n_s3_am = T_W'(FRAC_ONE) - r_s2_t;
    assign n_s3_ap = T_W'(FRAC_ONE) + r_s2_t;
    assign n_s3_tp = TP_W'(n_s3_am[TM_W-1:0]) * TP_W'(n_s3_ap[TM_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (stg_rdy[3]) begin
            r_s3_cfg <= r_s2_cfg;
            r_s3_v   <= r_s2_v;
            r_s3_s   <= r_s2_s;
            r_s3_t   <= r_s2_t;
            r_s3_q   <= r_s2_q;
            r_s3_tp  <= n_s3_tp;
        end
    end

    // Stage 4: pick the result for the configured function and saturate.
    always_comb begin
        if (r_s3_cfg.dir == DIR_FWD) begin
            case (r_s3_cfg.kind)
                ACT_SIGMOID: n_s4_wide = P_W'(r_s3_s);
                ACT_RELU:    n_s4_wide = (r_s3_v > 0) ? P_W'(r_s3_v) : '0;
                ACT_TANH:    n_s4_wide = P_W'(r_s3_t);
                default:     n_s4_wide = P_W'(r_s3_v);
            endcase
        end else begin
            case (r_s3_cfg.kind)
                ACT_SIGMOID: n_s4_wide = P_W'(r_s3_q);
                ACT_RELU:    n_s4_wide = (r_s3_v > 0) ? P_W'(FRAC_ONE) : '0;
                ACT_TANH:    n_s4_wide = P_W'(r_s3_tp[TP_W-1:FRAC_BITS]);
                default:     n_s4_wide = P_W'(FRAC_ONE);
            endcase
        end
        if (n_s4_wide > R_MAX) begin
            n_s4_res = V_MAX;
        end else if (n_s4_wide < R_MIN) begin
            n_s4_res = V_MIN;
        end else begin
            n_s4_res = n_s4_wide[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_rdy[4]) begin
            r_s4_res <= n_s4_res;
        end
    end

endmodule

`default_nettype wire

// ===== sv/activation_function_unit.sv =====
// An accepted input beat reaches the master side through five register
// stages (lookup, multiply, interpolate, tanh product, output register).
// Throughput: one beat per cycle while the master side does not stall.
// Reset (i_rst_n low at a clock edge) empties the pipeline and returns the
// configuration to identity, forward direction.
`default_nettype none

module activation_function_unit #(
    parameter int DATA_WIDTH = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // Configuration write channel.
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire [afu_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire [afu_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // Input stream.
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: [DATA_WIDTH-1:0] value (signed Q4.12), zero padding above.
    input  wire [((DATA_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata,
    // Result stream.
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // tdata: [DATA_WIDTH-1:0] result (signed Q4.12), zero padding above.
    output logic [((DATA_WIDTH + 7) / 8) * 8-1:0] m_axis_tdata
);
    import afu_pkg::*;

    localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

    // The datapath is a five-stage pipeline; each stage holds a valid bit and
    // loads whenever it is empty or the stage after it moves, so bubbles are
    // squeezed out and a stall on the master side holds every beat in place.
    // The tanh path reuses the sigmoid table: the doubled, saturated argument
    // goes through the lookup, and 2*s - 1 is formed in the third stage.
    // Derivatives that need a product use a dedicated multiplier each, one in
    // stage 1 for v*(1-v) and one in stage 3 for (1-t)(1+t).

    t_afu_cfg r_cfg;
    t_afu_cfg n_cfg;

    logic signed [DATA_WIDTH-1:0] core_result;
    logic [DATA_WIDTH-1:0]        core_result_u;

    // Configuration is taken in any cycle; the user is to change it only while
    // the pipeline is empty, unchecked here; each beat sees its entry setting.
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_KIND: n_cfg.kind = t_act_kind'(i_cfg_data[1:0]);
                REG_DIR:  n_cfg.dir  = t_dir'(i_cfg_data[0]);
                default:  n_cfg      = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{kind: ACT_NONE, dir: DIR_FWD};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    afu_core #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_value  ($signed(s_axis_tdata[DATA_WIDTH-1:0])),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (core_result)
    );

    assign core_result_u = core_result;
    assign m_axis_tdata  = TDATA_W'(core_result_u);

`ifndef SYNTHESIS
    // With the output register empty, every stage can load.
    a_ready_when_drained: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready
    ) else $error("input stalled while the output register is empty");

    // An accepted beat reaches the output, passing every stage in turn, when the
    // master side never stalls and no reset intervenes.
    a_fixed_latency: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        ($past(s_axis_tvalid && s_axis_tready, 5)
            && $past(m_axis_tready, 1) && $past(m_axis_tready, 2)
            && $past(m_axis_tready, 3) && $past(m_axis_tready, 4)
            && $past(i_rst_n, 1) && $past(i_rst_n, 2)
            && $past(i_rst_n, 3) && $past(i_rst_n, 4))
        |-> m_axis_tvalid
    ) else $error("beat did not arrive after the pipeline latency");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
module testbench;

    import afu_pkg::*;

    // Q4.12 at a 16-bit word: 1.0 is 4096.
    localparam int  WORD_W      = 16;
    localparam int  Q12_ONE     = 4096;
    // Five register stages inside the unit; settle() adds a margin on top.
    localparam int  PIPE_DEPTH  = 5;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  RANDOM_BEATS = 838;

    // Logistic sigmoid at the 65 segment endpoints over [-8, 8), in Q4.12.
    localparam int SIG_POINTS [0:64] = '{
        1, 2, 2, 3, 4, 5, 6, 8, 10, 13, 17, 21, 27, 35, 45, 58,
        74, 94, 120, 153, 194, 246, 311, 391, 488, 606, 747, 912, 1102, 1314, 1546, 1793,
        2048,
        2303, 2550, 2782, 2994, 3184, 3349, 3490, 3608, 3705, 3785, 3850, 3902, 3943, 3976,
        4002, 4022, 4038, 4051, 4061, 4069, 4075, 4079, 4083, 4086, 4088, 4090, 4091, 4092,
        4093, 4094, 4094, 4095
    };

    // Operands that sit on the edges of the fixed-point range, on sigmoid segment
    // boundaries, and on both sides of the point where doubling for tanh saturates.
    localparam logic [WORD_W-1:0] EDGE_OPERANDS [0:13] = '{
        16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h1000, 16'hF000,
        16'h3FFF, 16'h4000, 16'hC000, 16'hBFFF, 16'h03FF, 16'h0400, 16'hFC00
    };

    // One expected result beat, kept with the operand that caused it so that a
    // mismatch report can say what went in.
    typedef struct packed {
        logic [WORD_W-1:0] operand;
        logic [WORD_W-1:0] result;
    } t_pending_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // tdata: [15:0] value (signed Q4.12).
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // tdata: [15:0] result (signed Q4.12).
    logic [15:0] m_axis_tdata;

    // Operands waiting to be sent, and results waiting to come back.
    logic [WORD_W-1:0] operand_backlog [$];
    t_pending_result   result_queue [$];

    // Our own copy of the two configuration registers.
    t_act_kind kind_setting = ACT_NONE;
    t_dir      dir_setting  = DIR_FWD;

    // Sender state: a beat is on the bus and not yet taken.
    bit  beat_on_bus = 1'b0;
    int  burst_left  = 1;
    int  gap_left    = 0;

    // Receiver stall pattern, reshaped every so often.
    logic [7:0] ready_shape = 8'hFF;
    bit         ready_coin  = 1'b0;

    int  mismatch_count = 0;
    int  cycle_count    = 0;

    always #1 i_clk = ~i_clk;

    activation_function_unit #(
        .DATA_WIDTH(WORD_W)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Saturate to the signed 16-bit range.
    function automatic longint sat_word(longint x);
        if (x > 32767) begin
            return 32767;
        end else if (x < -32768) begin
            return -32768;
        end
        return x;
    endfunction

    // Piecewise-linear sigmoid: 64 segments of 1024 codes, the argument clamped
    // to [-8, 8) and the interpolation rounded toward zero (it is never negative).
    function automatic longint sigmoid_q12(longint x);
        longint u;
        longint seg;
        longint frac;
        longint lo;
        longint hi;
        if (x < -32768) x = -32768;
        if (x > 32767) x = 32767;
        u    = x + 32768;
        seg  = u >> 10;
        frac = u & 1023;
        lo   = SIG_POINTS[seg];
        hi   = SIG_POINTS[seg + 1];
        return lo + ((hi - lo) * frac) / 1024;
    endfunction

    // tanh(x) = 2 * sigmoid(2x) - 1, with the doubled argument saturated first.
    function automatic longint tanh_q12(longint x);
        return 2 * sigmoid_q12(sat_word(2 * x)) - Q12_ONE;
    endfunction

    // What the unit must return for one operand under the given setting. Products
    // are Q8.24 and come back to Q4.12 by a floor shift.
    function automatic logic [WORD_W-1:0] activation_result(t_act_kind kind, t_dir dir,
                                                             logic signed [WORD_W-1:0] operand);
        longint v;
        longint r;
        longint t;
        v = operand;
        if (dir == DIR_FWD) begin
            case (kind)
                ACT_SIGMOID: r = sigmoid_q12(v);
                ACT_RELU:    r = (v > 0) ? v : 0;
                ACT_TANH:    r = tanh_q12(v);
                default:     r = v;
            endcase
        end else begin
            case (kind)
                ACT_SIGMOID: r = (v * (Q12_ONE - v)) >>> 12;
                ACT_RELU:    r = (v > 0) ? Q12_ONE : 0;
                ACT_TANH: begin
                    t = tanh_q12(v);
                    r = ((Q12_ONE - t) * (Q12_ONE + t)) >>> 12;
                end
                default:     r = Q12_ONE;
            endcase
        end
        r = sat_word(r);
        return r[WORD_W-1:0];
    endfunction

    // Random operands lean toward the interesting parts of the curve: the
    // transition region, around zero, the range edges, segment boundaries, and the
    // point where doubling for tanh saturates. Plain random words cover every bit.
    function automatic logic [WORD_W-1:0] pick_operand();
        int x;
        case ($urandom_range(0, 5))
            0: x = $urandom_range(0, 65535);
            1: x = int'($urandom_range(0, 32767)) - 16384;
            2: x = int'($urandom_range(0, 256)) - 128;
            3: x = ($urandom_range(0, 1) != 0) ? 32767 - int'($urandom_range(0, 63))
                                               : -32768 + int'($urandom_range(0, 63));
            4: x = int'($urandom_range(0, 63)) * 1024 - 32768 + int'($urandom_range(0, 2)) - 1;
            default: x = (($urandom_range(0, 1) != 0) ? 16384 : -16384)
                         + int'($urandom_range(0, 8)) - 4;
        endcase
        return x[WORD_W-1:0];
    endfunction

    // Write one configuration register. Our copy follows the index decode of the
    // unit: only the low bits count, and an index past the last register is ignored.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_KIND) begin
            kind_setting = t_act_kind'(data[1:0]);
        end else if (idx == REG_DIR) begin
            dir_setting = t_dir'(data[0]);
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_IDX_W'($urandom);
        i_cfg_data  <= CFG_DATA_W'($urandom);
    endtask

    // Wait until every beat has gone out and every result has come back, then give the
    // pipeline time to run dry before anything else happens.
    task automatic settle();
        do @(negedge i_clk);
        while (operand_backlog.size() != 0 || beat_on_bus || result_queue.size() != 0);
        repeat (PIPE_DEPTH + 3) @(negedge i_clk);
    endtask

    // Set both registers, with random junk in the unused upper data bits.
    task automatic apply_setting(input t_act_kind kind, input t_dir dir);
        logic [CFG_DATA_W-1:0] cfg_byte;
        cfg_byte      = CFG_DATA_W'($urandom);
        cfg_byte[1:0] = kind;
        write_reg(REG_KIND, cfg_byte);
        cfg_byte      = CFG_DATA_W'($urandom);
        cfg_byte[0]   = dir;
        write_reg(REG_DIR, cfg_byte);
    endtask

    // Main sequence: reset, a directed pass over every setting, then random phases.
    // Each phase ends with the sender paused until the unit has drained, which is
    // also when the configuration may be rewritten.
    initial begin
        int sent;
        int phase_len;
        int k;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The first directed pass runs on the reset setting, no writes before it.
        for (k = 0; k < 8; k++) begin
            if (k != 0) begin
                apply_setting(t_act_kind'(k >> 1), t_dir'(k & 1));
            end
            // An index past the last register must leave the setting alone.
            if (k == 4) begin
                write_reg(CFG_IDX_W'($urandom_range(2, 255)), CFG_DATA_W'($urandom));
            end
            @(posedge i_clk);
            foreach (EDGE_OPERANDS[j]) operand_backlog.push_back(EDGE_OPERANDS[j]);
            settle();
        end

        sent = 0;
        while (sent < RANDOM_BEATS) begin
            // Mostly a full rewrite, sometimes only one register, and now and
            // then a write to an index that does not exist.
            case ($urandom_range(0, 5))
                0: write_reg(REG_KIND, CFG_DATA_W'($urandom));
                1: write_reg(REG_DIR, CFG_DATA_W'($urandom));
                default: apply_setting(t_act_kind'($urandom_range(0, 3)),
                                       t_dir'($urandom_range(0, 1)));
            endcase
            if ($urandom_range(0, 3) == 0) begin
                write_reg(CFG_IDX_W'($urandom_range(2, 255)), CFG_DATA_W'($urandom));
            end
            phase_len = $urandom_range(10, 80);
            if (phase_len > RANDOM_BEATS - sent) phase_len = RANDOM_BEATS - sent;
            @(posedge i_clk);
            repeat (phase_len) operand_backlog.push_back(pick_operand());
            sent += phase_len;
            settle();
        end

        if (result_queue.size() != 0) begin
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("PASS activation_function_unit");
        end else begin
            $display("FAIL activation_function_unit");
        end
        $finish;
    end

    // Sender. A new beat goes out only once the previous one was taken; beats go
    // in bursts of random length separated by random gaps, and about a third of
    // the bursts follow each other with no gap at all.
    always @(negedge i_clk) begin
        if (!beat_on_bus) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= WORD_W'($urandom);
            end else if (operand_backlog.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= operand_backlog.pop_front();
                beat_on_bus = 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end else begin
                    burst_left--;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= WORD_W'($urandom);
            end
        end
    end

    // Every accepted input beat is turned into its expected result right away,
    // using the setting in force; the setting never changes with beats in flight.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            result_queue.push_back('{operand: s_axis_tdata,
                result: activation_result(kind_setting, dir_setting, s_axis_tdata)});
            beat_on_bus = 1'b0;
        end
    end

    // Receiver. It repeatedly picks a new stall shape: always ready, a fixed random
    // pattern, the fixed pattern 8'h11, or a coin flip per cycle.
    always @(negedge i_clk) begin
        if (cycle_count % 50 == 0) begin
            case ($urandom_range(0, 3))
                0: ready_shape = 8'hFF;
                1: ready_shape = 8'($urandom);
                2: ready_shape = 8'h11;
                default: ready_shape = 8'h00;
            endcase
            ready_coin = (ready_shape == 8'h00);
        end
        if (ready_coin) begin
            m_axis_tready <= 1'($urandom_range(0, 1));
        end else begin
            m_axis_tready <= ready_shape[cycle_count % 8];
        end
    end

    // Result checker: each result beat must match the oldest expectation.
    always @(posedge i_clk) begin
        t_pending_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (result_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result beat %h with nothing outstanding", m_axis_tdata);
                end
            end else begin
                want = result_queue.pop_front();
                if (m_axis_tdata !== want.result) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("result mismatch: value %0d kind %s dir %s expected %0d got %0d",
                                 $signed(want.operand), kind_setting.name(), dir_setting.name(),
                                 $signed(want.result), $signed(m_axis_tdata));
                    end
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL activation_function_unit");
            $finish;
        end
    end

endmodule

// ===== files.f =====
sv/afu_pkg.sv
sv/afu_core.sv
sv/activation_function_unit.sv
tb/testbench.sv
